/* rtl/msd_pkg.sv */
package msd_pkg;

    localparam int RATE_W  = 16;
    localparam int TS_W    = 63;
    localparam int LEVEL_W = 13;
    localparam int COUNT_W = 16;
    localparam int MS_W    = 16;
    localparam int NS_W    = 36;   // 65535 ms in ns fits in 36 bits
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 16;

    localparam logic [LEVEL_W-1:0] ONE_Q12   = 13'd4096;
    localparam logic [NS_W-1:0]    NS_PER_MS = 36'd1000000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_STATIC_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DYNAMIC_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAMES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TIME_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME_MS = 3'd4;

    typedef enum logic [1:0] {
        ST_STATIC  = 2'd0,
        ST_MOVING  = 2'd1,
        ST_DYNAMIC = 2'd2
    } motion_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] static_thr;
        logic [LEVEL_W-1:0] dynamic_thr;
        logic [COUNT_W-1:0] min_frames;
        logic [NS_W-1:0]    min_time_ns;
        logic [NS_W-1:0]    hold_ns;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] intensity;
        logic               changed;
        logic [1:0]         state;
    } result_t;

endpackage

/* rtl/motion_state_debouncer.sv */
// Motion state debouncer.
// Input stream s_*: one beat per sample, tdata = filtered_rate (Q4.12) and a
// 63-bit sample time in ns. Output stream m_*: one beat per input beat, tdata =
// motion state, change flag and clamped intensity.
// Configuration: cfg_we/cfg_index/cfg_wdata write one register per cycle;
// write only while no beat is in flight.
// Path: a beat accepted on s_* sits in the input register, is processed into
// the result register, and can then leave on m_*. Throughput: one beat per
// cycle while m_tready stays high; the state update is a single pass of compares
// and 64-bit subtracts between the two registers.
// Stall: when m_tready is low the result holds, one more beat can sit in the
// input register, then s_tready drops until the output drains.
// Reset: both stages empty, state static, no change recorded, counters
// cleared, configuration back to its defaults.
module motion_state_debouncer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [15:0] filtered_rate, [78:16] sample time in ns, [79] zero
    input  logic [msd_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [1:0] motion_state, [2] state_changed, [15:3] intensity
    output logic [msd_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             cfg_we,
    input  logic [msd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [msd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    msd_pkg::cfg_t                cfg;
    msd_pkg::result_t             result;
    logic                         in_valid_reg;
    logic [msd_pkg::RATE_W-1:0]   rate_reg;
    logic [msd_pkg::TS_W-1:0]     ts_reg;
    logic                         out_valid_reg;
    msd_pkg::result_t             out_reg;
    logic                         advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    msd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    msd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rate    (rate_reg),
        .now     (ts_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            rate_reg <= s_tdata[msd_pkg::RATE_W-1:0];
            ts_reg   <= s_tdata[msd_pkg::RATE_W+msd_pkg::TS_W-1:msd_pkg::RATE_W];
        end
        if (advance)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

/* rtl/msd_cfg.sv */
module msd_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [msd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [msd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output msd_pkg::cfg_t                    cfg
);

    msd_pkg::cfg_t cfg_reg;
    logic [msd_pkg::NS_W-1:0] wdata_ns;

    // ms limits are kept in ns so the item path only compares
    assign wdata_ns = {{(msd_pkg::NS_W-msd_pkg::CFG_DATA_W){1'b0}}, cfg_wdata}
                      * msd_pkg::NS_PER_MS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.static_thr   <= 13'd410;
            cfg_reg.dynamic_thr  <= 13'd2048;
            cfg_reg.min_frames   <= 16'd5;
            cfg_reg.min_time_ns  <= 36'd100000000;
            cfg_reg.hold_ns      <= 36'd200000000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                msd_pkg::REG_STATIC_THR:   cfg_reg.static_thr   <= cfg_wdata[msd_pkg::LEVEL_W-1:0];
                msd_pkg::REG_DYNAMIC_THR:  cfg_reg.dynamic_thr  <= cfg_wdata[msd_pkg::LEVEL_W-1:0];
                msd_pkg::REG_MIN_FRAMES:   cfg_reg.min_frames   <= cfg_wdata;
                msd_pkg::REG_MIN_TIME_MS:  cfg_reg.min_time_ns  <= wdata_ns;
                msd_pkg::REG_HOLD_TIME_MS: cfg_reg.hold_ns      <= wdata_ns;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/msd_core.sv */
module msd_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [msd_pkg::RATE_W-1:0]    rate,
    input  logic [msd_pkg::TS_W-1:0]      now,
    input  msd_pkg::cfg_t                 cfg,
    output msd_pkg::result_t              result
);

    msd_pkg::motion_t             cur_reg, cur_next;
    msd_pkg::motion_t             cand_reg, cand_next;
    logic [msd_pkg::TS_W-1:0]     cand_time_reg, cand_time_next;
    logic [msd_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [msd_pkg::TS_W-1:0]     change_time_reg, change_time_next;

    logic [msd_pkg::LEVEL_W-1:0]  level;
    msd_pkg::motion_t             seen;
    logic [msd_pkg::COUNT_W-1:0]  count_inc;
    logic [63:0]                  since_cand;
    logic [63:0]                  since_change;
    logic                         time_ok;
    logic                         frames_ok;
    logic                         hold_ok;
    logic                         change;

    always_comb
    begin
        if (rate > {{(msd_pkg::RATE_W-msd_pkg::LEVEL_W){1'b0}}, msd_pkg::ONE_Q12})
            level = msd_pkg::ONE_Q12;
        else
            level = rate[msd_pkg::LEVEL_W-1:0];

        // static test wins when thresholds cross
        if (level < cfg.static_thr)
            seen = msd_pkg::ST_STATIC;
        else if (level >= cfg.dynamic_thr)
            seen = msd_pkg::ST_DYNAMIC;
        else
            seen = msd_pkg::ST_MOVING;

        count_inc = (count_reg == msd_pkg::COUNT_MAX) ? count_reg : count_reg + 16'd1;

        // signed differences; a negative one fails its test
        since_cand   = {1'b0, now} - {1'b0, cand_time_reg};
        since_change = {1'b0, now} - {1'b0, change_time_reg};
        time_ok   = !since_cand[63]
                    && (since_cand >= {{(64-msd_pkg::NS_W){1'b0}}, cfg.min_time_ns});
        frames_ok = count_inc >= cfg.min_frames;
        hold_ok   = (!since_change[63]
                    && (since_change >= {{(64-msd_pkg::NS_W){1'b0}}, cfg.hold_ns}))
                    || (change_time_reg == '0);

        cur_next         = cur_reg;
        cand_next        = cand_reg;
        cand_time_next   = cand_time_reg;
        count_next       = count_reg;
        change_time_next = change_time_reg;
        change           = 1'b0;

        if (seen == cur_reg)
        begin
            count_next = '0;
            cand_next  = cur_reg;
        end
        else if (seen == cand_reg)
        begin
            count_next = count_inc;
            change     = (time_ok || frames_ok) && hold_ok;
        end
        else
        begin
            cand_next      = seen;
            cand_time_next = now;
            count_next     = 16'd1;
        end

        if (change)
        begin
            change_time_next = now;
            count_next       = '0;
            cand_next        = seen;
            cur_next         = seen;
        end

        result.state     = cur_next;
        result.changed   = change;
        result.intensity = level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg         <= msd_pkg::ST_STATIC;
            cand_reg        <= msd_pkg::ST_STATIC;
            cand_time_reg   <= '0;
            count_reg       <= '0;
            change_time_reg <= '0;
        end
        else if (advance)
        begin
            cur_reg         <= cur_next;
            cand_reg        <= cand_next;
            cand_time_reg   <= cand_time_next;
            count_reg       <= count_next;
            change_time_reg <= change_time_next;
        end
    end

endmodule

/* verif/motion_state_checker.sv */
module motion_state_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [15:0] filtered_rate, [78:16] sample time in ns, [79] zero
    input  logic [msd_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] motion_state, [2] state_changed, [15:3] intensity
    input  logic [msd_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic [msd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              fail_count,
    output int                              outstanding,
    output int                              results_checked,
    output int                              switches_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import msd_pkg::*;

    localparam longint NS_IN_MS = 64'sd1000000;

    // register shadow
    logic [LEVEL_W-1:0] thr_static;
    logic [LEVEL_W-1:0] thr_dynamic;
    logic [COUNT_W-1:0] min_frames;
    logic [MS_W-1:0]    min_time_ms;
    logic [MS_W-1:0]    hold_ms;

    // debouncer state
    motion_t            cur_state;
    motion_t            cand_state;
    longint             cand_start;
    longint             last_change;
    logic [COUNT_W-1:0] frame_cnt;

    result_t            expected_states [$];
    result_t            got;
    result_t            want;
    int                 n_bad;
    int                 n_checked;
    int                 n_switch;

    function automatic result_t debounce_step(input logic [RATE_W-1:0] rate,
                                              input logic [TS_W-1:0] stamp);
        logic [LEVEL_W-1:0] level;
        motion_t            seen;
        logic               switch_now;
        longint             now_ns;
        longint             since_cand;
        longint             since_change;
        result_t            r;

        level = (rate > ONE_Q12) ? ONE_Q12 : rate[LEVEL_W-1:0];
        // static test wins when the thresholds are crossed
        if (level < thr_static)
            seen = ST_STATIC;
        else if (level >= thr_dynamic)
            seen = ST_DYNAMIC;
        else
            seen = ST_MOVING;

        now_ns = longint'({1'b0, stamp});
        switch_now = 1'b0;

        if (seen == cur_state)
        begin
            frame_cnt = '0;
            cand_state = cur_state;
        end
        else if (seen == cand_state)
        begin
            if (frame_cnt != COUNT_MAX)
                frame_cnt = frame_cnt + 1'b1;
            since_cand = now_ns - cand_start;
            if (since_cand >= longint'(min_time_ms) * NS_IN_MS
                || frame_cnt >= min_frames)
            begin
                since_change = now_ns - last_change;
                // a change stamped at time zero still reads as no change yet
                if (since_change >= longint'(hold_ms) * NS_IN_MS || last_change == 0)
                    switch_now = 1'b1;
            end
        end
        else
        begin
            cand_state = seen;
            cand_start = now_ns;
            frame_cnt = 16'd1;
        end

        if (switch_now)
        begin
            last_change = now_ns;
            frame_cnt = '0;
            cand_state = seen;
            cur_state = seen;
        end

        r.state = cur_state;
        r.changed = switch_now;
        r.intensity = level;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_static = 13'd410;
            thr_dynamic = 13'd2048;
            min_frames = 16'd5;
            min_time_ms = 16'd100;
            hold_ms = 16'd200;
            cur_state = ST_STATIC;
            cand_state = ST_STATIC;
            cand_start = 0;
            last_change = 0;
            frame_cnt = '0;
            expected_states.delete();
            n_bad = 0;
            n_checked = 0;
            n_switch = 0;
            fail_count <= 0;
            outstanding <= 0;
            results_checked <= 0;
            switches_seen <= 0;
        end
        else
        begin
            // retire before predicting so a beat can never match its own input
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata);
                if (expected_states.size() == 0)
                begin
                    n_bad++;
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_states.pop_front();
                    n_checked++;
                    if (want.changed)
                        n_switch++;
                    if (got.state !== want.state)
                    begin
                        n_bad++;
                        $display("%0t: motion_state expected %0d actual %0d",
                                 $time, want.state, got.state);
                    end
                    if (got.changed !== want.changed)
                    begin
                        n_bad++;
                        $display("%0t: state_changed expected %0d actual %0d",
                                 $time, want.changed, got.changed);
                    end
                    if (got.intensity !== want.intensity)
                    begin
                        n_bad++;
                        $display("%0t: intensity expected %0d actual %0d",
                                 $time, want.intensity, got.intensity);
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STATIC_THR:   thr_static = cfg_wdata[LEVEL_W-1:0];
                    REG_DYNAMIC_THR:  thr_dynamic = cfg_wdata[LEVEL_W-1:0];
                    REG_MIN_FRAMES:   min_frames = cfg_wdata;
                    REG_MIN_TIME_MS:  min_time_ms = cfg_wdata;
                    REG_HOLD_TIME_MS: hold_ms = cfg_wdata;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                expected_states.push_back(debounce_step(s_tdata[RATE_W-1:0],
                                                        s_tdata[RATE_W +: TS_W]));

            fail_count <= n_bad;
            outstanding <= expected_states.size();
            results_checked <= n_checked;
            switches_seen <= n_switch;
        end
    end

endmodule

/* verif/motion_state_debouncer_tb.sv */
module motion_state_debouncer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msd_pkg::*;

    localparam logic [TS_W-1:0] MS = 63'd1000000;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_PHASES = 6;
    localparam int BEATS_PER_PHASE = 250;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [15:0] filtered_rate, [78:16] sample time in ns, [79] zero
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [1:0] motion_state, [2] state_changed, [15:3] intensity
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int fail_count;
    int outstanding;
    int results_checked;
    int switches_seen;

    int snd_idle_pct = 14;
    int rcv_idle_pct = 73;
    int st_thr = 410;
    int dyn_thr = 2048;
    int samples_sent = 0;
    int profiles = 0;
    int quiet_cycles = 0;

    motion_state_debouncer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    motion_state_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .switches_seen   (switches_seen)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[motion_state_debouncer] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_sample(input logic [RATE_W-1:0] rate, input logic [TS_W-1:0] stamp);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, stamp, rate};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        samples_sent++;
    endtask

    // step past the current edge first so the count includes a beat taken at this very edge
    task automatic wait_results_drained;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] v_static, input logic [15:0] v_dynamic,
                            input logic [15:0] v_frames, input logic [15:0] v_time,
                            input logic [15:0] v_hold);
        cfg_we <= 1'b1;
        cfg_index <= REG_STATIC_THR;
        cfg_wdata <= v_static;
        @(posedge clk);
        cfg_index <= REG_DYNAMIC_THR;
        cfg_wdata <= v_dynamic;
        @(posedge clk);
        cfg_index <= REG_MIN_FRAMES;
        cfg_wdata <= v_frames;
        @(posedge clk);
        cfg_index <= REG_MIN_TIME_MS;
        cfg_wdata <= v_time;
        @(posedge clk);
        cfg_index <= REG_HOLD_TIME_MS;
        cfg_wdata <= v_hold;
        @(posedge clk);
        cfg_we <= 1'b0;
        st_thr = int'(v_static);
        dyn_thr = int'(v_dynamic);
        profiles++;
    endtask

    initial
    begin
        logic [RATE_W-1:0] rate;
        logic [TS_W-1:0]   ts_now;
        int                run_cls;
        int                run_left;
        int                lo;
        int                pick;

        run_cls = 0;
        run_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: 410 / 2048, 5 frames, 100 ms, 200 ms hold
        send_sample(16'd0, 63'd0);
        // switch to dynamic with every sample stamped zero, clamping on the way
        send_sample(16'd65535, 63'd0);
        send_sample(16'd4097, 63'd0);
        send_sample(16'd4096, 63'd0);
        send_sample(16'd4096, 63'd0);
        send_sample(16'd4096, 63'd0);
        // hold test must still pass: last change was at time zero
        send_sample(16'd2047, 63'd0);
        send_sample(16'd410, 63'd0);
        send_sample(16'd1000, 63'd0);
        send_sample(16'd2000, 63'd0);
        send_sample(16'd2047, 63'd0);
        // time running backwards, then back to the current state
        send_sample(16'd409, 10 * MS);
        send_sample(16'd0, 5 * MS);
        send_sample(16'd410, 6 * MS);
        // switch on elapsed time alone
        send_sample(16'd100, 300 * MS);
        send_sample(16'd50, 401 * MS);
        // hold time just short, then just met
        send_sample(16'd2048, 402 * MS);
        send_sample(16'd3000, 600 * MS);
        send_sample(16'd4096, 601 * MS);
        send_sample(16'd1500, {TS_W{1'b1}});
        send_sample(16'd1500, {TS_W{1'b1}});
        send_sample(16'd65535, {TS_W{1'b1}});
        wait_results_drained();

        ts_now = 63'd5000000000;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p / 2)
                0:
                begin
                    snd_idle_pct <= 14;
                    rcv_idle_pct <= 73;
                end
                1:
                begin
                    snd_idle_pct <= 73;
                    rcv_idle_pct <= 14;
                end
                default:
                begin
                    snd_idle_pct <= 0;
                    rcv_idle_pct <= 0;
                end
            endcase
            case (p)
                0: set_regs(16'd600, 16'd2500, 16'd4, 16'd60, 16'd120);
                1: set_regs(16'd0, 16'd4096, 16'd0, 16'd0, 16'd0);
                2: set_regs(16'd4096, 16'd0, 16'd65535, 16'd65535, 16'd65535);
                3: set_regs(16'd3000, 16'd1000, 16'd3, 16'd30, 16'd0);
                4: set_regs(16'd410, 16'd2048, 16'd5, 16'd100, 16'd200);
                default: set_regs(16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)),
                                  16'($urandom_range(0, 8)), 16'($urandom_range(0, 150)),
                                  16'($urandom_range(0, 300)));
            endcase

            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                // runs of one class so candidates get a chance to mature
                if (run_left == 0)
                begin
                    run_cls = $urandom_range(0, 2);
                    run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40)
                                                           : $urandom_range(1, 12);
                end
                run_left--;

                if ($urandom_range(0, 9) == 0)
                    rate = 16'($urandom_range(0, 65535));
                else if (run_cls == 0)
                    rate = (st_thr > 0) ? 16'($urandom_range(0, st_thr - 1))
                                        : 16'($urandom_range(0, 65535));
                else if (run_cls == 1)
                    rate = (st_thr < dyn_thr) ? 16'($urandom_range(st_thr, dyn_thr - 1))
                                              : 16'($urandom_range(0, 65535));
                else
                begin
                    lo = (st_thr > dyn_thr) ? st_thr : dyn_thr;
                    rate = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(lo, 4096))
                                                       : 16'($urandom_range(lo, 65535));
                end

                pick = $urandom_range(0, 99);
                if (pick < 80)
                    ts_now = ts_now + 63'($urandom_range(0, 30)) * MS
                                    + 63'($urandom_range(0, 999999));
                else if (pick < 86)
                    ts_now = ts_now;
                else if (pick < 91)
                    ts_now = ts_now - 63'($urandom_range(1, 300)) * MS;
                else if (pick < 95)
                    ts_now = ts_now + 63'($urandom);
                else if (pick < 98)
                    ts_now = 63'({$urandom, $urandom});
                else
                    ts_now = '0;

                send_sample(rate, ts_now);

                if ($urandom_range(0, 99) == 0)
                    wait_results_drained();
            end
            wait_results_drained();
        end

        $display("run covered %0d sample beats under %0d register settings plus reset values,",
                 samples_sent, profiles);
        $display("including crossed and extreme limits; %0d results checked, %0d switches",
                 results_checked, switches_seen);
        if (fail_count == 0)
            $display("[motion_state_debouncer] OK");
        else
            $display("[motion_state_debouncer] ERROR");
        $finish;
    end

endmodule
